@@ design/magnetometer_hard_soft_iron_calibration_core_defines.svh @@
// ----------------------------------------------------------------------------
// Calibration core assertion macros
// Shared concurrent assertion forms for the calibration core.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_HARD_SOFT_IRON_CALIBRATION_CORE_DEFINES_SVH
`define MAGNETOMETER_HARD_SOFT_IRON_CALIBRATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calibration core check failed");

// Next-cycle implication, disabled during reset.
`define MC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calibration core check failed");

`endif

@@ design/mag_cal_pkg.sv @@
// ----------------------------------------------------------------------------
// Calibration core package
// Shared constants and types of the calibration core.
// ----------------------------------------------------------------------------
package mag_cal_pkg;

  localparam int COUNT_WIDTH_DEF = 12;
  localparam int JOBQ_DEPTH = 2;

  localparam logic [2:0] REG_RUN_LENGTH = 3'd0;
  localparam logic [2:0] REG_RESOLUTION = 3'd1;
  localparam logic [2:0] REG_SENS_X = 3'd2;
  localparam logic [2:0] REG_SENS_Y = 3'd3;
  localparam logic [2:0] REG_SENS_Z = 3'd4;

  localparam logic signed [15:0] AXIS_START_MAX = -16'sd32767;
  localparam logic signed [15:0] AXIS_START_MIN = 16'sd32767;

  // Both scales reduce to a multiply and a division by 4095:
  // 49120/32760 = 6140/4095 and 49120/8190 = 4*6140/4095.
  localparam logic [12:0] SCALE_16BIT = 13'd6140;
  localparam logic [12:0] DEN_SHARED = 13'd4095;
  localparam logic [11:0] ROUND_HALF = 12'd2047;
  localparam logic [23:0] RATIO_SAT = 24'hFFFFFF;

  typedef struct packed {
    logic [2:0][15:0] amax;
    logic [2:0][15:0] amin;
  } job_t;

  typedef struct packed {
    logic       resolution_16bit;
    logic [7:0] sens_adjust_x;
    logic [7:0] sens_adjust_y;
    logic [7:0] sens_adjust_z;
  } cfg_t;

endpackage

@@ design/mag_cal_front.sv @@
// ----------------------------------------------------------------------------
// Calibration front end
// Selects the sample in use, tracks per-axis extremes and closes each run.
// ----------------------------------------------------------------------------
module mag_cal_front #(
  parameter int COUNT_WIDTH = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 data_ready,
  input  logic                 overflow,
  input  logic signed [15:0]   mag_x,
  input  logic signed [15:0]   mag_y,
  input  logic signed [15:0]   mag_z,
  input  logic [11:0]          run_length,
  output logic                 job_push,
  output mag_cal_pkg::job_t    job
);
  import mag_cal_pkg::*;

  localparam logic [16:0] LIMIT = 17'((1 << COUNT_WIDTH) - 1);

  logic signed [15:0] held [3];
  logic signed [15:0] amax [3];
  logic signed [15:0] amin [3];
  logic signed [15:0] sel  [3];
  logic signed [15:0] nmax [3];
  logic signed [15:0] nmin [3];
  logic signed [15:0] mag  [3];
  logic [COUNT_WIDTH-1:0] samples_seen;
  logic [16:0] tgt;
  logic [16:0] seen_inc;
  logic        take;
  logic        done;

  assign mag[0] = mag_x;
  assign mag[1] = mag_y;
  assign mag[2] = mag_z;
  assign take = data_ready & ~overflow;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sel[i]  = take ? mag[i] : held[i];
      nmax[i] = (sel[i] > amax[i]) ? sel[i] : amax[i];
      nmin[i] = (sel[i] < amin[i]) ? sel[i] : amin[i];
      job.amax[i] = nmax[i];
      job.amin[i] = nmin[i];
    end
    tgt = {5'd0, run_length};
    if (tgt > LIMIT) tgt = LIMIT;
    if (tgt == 17'd0) tgt = 17'd1;
    seen_inc = 17'(samples_seen) + 17'd1;
    done = (seen_inc >= tgt);
  end

  assign job_push = accept & done;

  always_ff @(posedge clk) begin
    if (rst || (accept && done)) begin
      for (int i = 0; i < 3; i++) begin
        held[i] <= '0;
        amax[i] <= AXIS_START_MAX;
        amin[i] <= AXIS_START_MIN;
      end
      samples_seen <= '0;
    end else if (accept) begin
      for (int i = 0; i < 3; i++) begin
        held[i] <= sel[i];
        amax[i] <= nmax[i];
        amin[i] <= nmin[i];
      end
      samples_seen <= seen_inc[COUNT_WIDTH-1:0];
    end
  end

endmodule

@@ design/mag_cal_jobq.sv @@
// ----------------------------------------------------------------------------
// Calibration job queue
// Short queue of finished runs between the front end and the arithmetic unit.
// ----------------------------------------------------------------------------
`include "magnetometer_hard_soft_iron_calibration_core_defines.svh"

module mag_cal_jobq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mag_cal_pkg::job_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output mag_cal_pkg::job_t rdata
);
  import mag_cal_pkg::*;

  job_t       mem [JOBQ_DEPTH];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'(JOBQ_DEPTH));
  assign valid = (count != 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && valid) rptr <= ~rptr;
      count <= count + 2'(push && !full) - 2'(pop && valid);
    end
  end

  `MC_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= 2'(JOBQ_DEPTH))
  `MC_ASSERT_NOW(a_no_push_full, clk, rst, full, !push)
  `MC_ASSERT_NEXT(a_push_grows, clk, rst, push && !full && !pop, count == $past(count) + 2'd1)

endmodule

@@ design/mag_cal_back.sv @@
// ----------------------------------------------------------------------------
// Calibration arithmetic unit
// Computes the bias of one run by digit steps of a constant divisor and the
// soft-iron ratios with a serial divider.
// ----------------------------------------------------------------------------
module mag_cal_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  mag_cal_pkg::job_t  job,
  output logic               job_pop,
  input  mag_cal_pkg::cfg_t  cfg,
  input  logic               pop,
  output logic               empty,
  output logic signed [27:0] bias_x_mg,
  output logic signed [27:0] bias_y_mg,
  output logic signed [27:0] bias_z_mg,
  output logic [23:0]        ratio_x,
  output logic [23:0]        ratio_y,
  output logic [23:0]        ratio_z,
  output logic               zero_chord
);
  import mag_cal_pkg::*;

  localparam int NUM_W = 48;
  localparam int CDIV_STEPS = 4;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_STORE = 3'd6;
  localparam logic [2:0] ST_CDIV = 3'd7;

  logic [2:0]  state;
  logic        res_valid;
  job_t        jr;
  logic [1:0]  axis;
  logic        rphase;
  logic [14:0] bmag [3];
  logic        bneg [3];
  logic [15:0] h [3];
  logic [16:0] sum;
  logic [30:0] p1;
  logic [39:0] p2;
  logic [NUM_W-1:0] num;
  logic [16:0] den;
  logic [16:0] rem;
  logic [5:0]  cnt;
  logic [27:0] bias [3];
  logic [23:0] ratio [3];
  logic        zflag;

  logic [7:0]  asa;
  logic [8:0]  gain;
  logic [16:0] h3;
  logic [17:0] trial;
  logic [12:0] csum;
  logic signed [16:0] s_sum [3];
  logic signed [16:0] s_dif [3];
  logic signed [16:0] b_val [3];
  logic signed [16:0] d_val [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_sum[i] = 17'($signed(jr.amax[i])) + 17'($signed(jr.amin[i]));
      s_dif[i] = 17'($signed(jr.amax[i])) - 17'($signed(jr.amin[i]));
      b_val[i] = $signed(s_sum[i] + 17'(s_sum[i][16])) >>> 1;
      d_val[i] = $signed(s_dif[i] + 17'(s_dif[i][16])) >>> 1;
    end
    case (axis)
      2'd0:    asa = cfg.sens_adjust_x;
      2'd1:    asa = cfg.sens_adjust_y;
      default: asa = cfg.sens_adjust_z;
    endcase
    gain  = 9'(asa) + 9'd128;
    h3    = 17'(h[axis]) + {h[axis], 1'b0};
    trial = {rem, num[NUM_W-1]};
    // One base-4096 digit step of a division by 4095: the partial dividend
    // rem*4096 + digit equals rem*4095 + (rem + digit).
    csum  = 13'(rem[11:0]) + 13'(num[NUM_W-1 -: 12]);
  end

  assign job_pop = (state == ST_IDLE) && job_valid && !res_valid;
  assign empty   = !res_valid;
  assign bias_x_mg = bias[0];
  assign bias_y_mg = bias[1];
  assign bias_z_mg = bias[2];
  assign ratio_x = ratio[0];
  assign ratio_y = ratio[1];
  assign ratio_z = ratio[2];
  assign zero_chord = zflag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (job_pop) begin
            jr    <= job;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            bneg[i] <= b_val[i][16];
            bmag[i] <= b_val[i][16] ? 15'(-b_val[i]) : b_val[i][14:0];
            h[i]    <= d_val[i][16] ? 16'd0 : d_val[i][15:0];
          end
          sum <= (d_val[0][16] ? 17'd0 : d_val[0]) + (d_val[1][16] ? 17'd0 : d_val[1])
                 + (d_val[2][16] ? 17'd0 : d_val[2]);
          axis   <= 2'd0;
          rphase <= 1'b0;
          zflag  <= 1'b0;
          state  <= ST_MUL1;
        end
        ST_MUL1: begin
          p1    <= 31'(bmag[axis]) * 31'(SCALE_16BIT);
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          p2    <= 40'(p1) * 40'(gain);
          state <= ST_PREP;
        end
        ST_PREP: begin
          rem <= '0;
          if (!rphase) begin
            // The 14-bit scale is four times the 16-bit one over the same 4095.
            num   <= NUM_W'(cfg.resolution_16bit ? p2 : {p2[37:0], 2'b00})
                     + NUM_W'(ROUND_HALF);
            cnt   <= 6'(CDIV_STEPS);
            state <= ST_CDIV;
          end else if (h[axis] == 16'd0) begin
            num   <= NUM_W'(RATIO_SAT);
            zflag <= 1'b1;
            state <= ST_STORE;
          end else begin
            den   <= h3;
            num   <= (NUM_W'(sum) << 16) + NUM_W'(h3 >> 1);
            cnt   <= 6'(NUM_W);
            state <= ST_DIV;
          end
        end
        ST_CDIV: begin
          if (csum >= DEN_SHARED) begin
            rem <= 17'(csum - DEN_SHARED);
            num <= {num[NUM_W-13:0], rem[11:0] + 12'd1};
          end else begin
            rem <= 17'(csum);
            num <= {num[NUM_W-13:0], rem[11:0]};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= ST_STORE;
        end
        ST_DIV: begin
          if (trial >= {1'b0, den}) begin
            rem <= 17'(trial - {1'b0, den});
            num <= {num[NUM_W-2:0], 1'b1};
          end else begin
            rem <= trial[16:0];
            num <= {num[NUM_W-2:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= ST_STORE;
        end
        ST_STORE: begin
          if (!rphase) begin
            bias[axis] <= bneg[axis] ? -num[27:0] : num[27:0];
          end else begin
            ratio[axis] <= (num > NUM_W'(RATIO_SAT)) ? RATIO_SAT : num[23:0];
          end
          if (axis == 2'd2) begin
            axis <= 2'd0;
            if (rphase) begin
              res_valid <= 1'b1;
              state     <= ST_IDLE;
            end else begin
              rphase <= 1'b1;
              state  <= ST_PREP;
            end
          end else begin
            axis  <= axis + 2'd1;
            state <= rphase ? ST_PREP : ST_MUL1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/magnetometer_hard_soft_iron_calibration_core.sv @@
// ----------------------------------------------------------------------------
// Magnetometer hard/soft-iron calibration core
// Min/max tracking of readings with one bias and ratio result per run.
// ----------------------------------------------------------------------------
// A reading transaction is accepted in any cycle in which the job queue has
// room; the transaction that completes a run closes it in that same cycle.
// Once the back end takes the run, its result is computed in steps: load, then per
// bias axis two multiplies, setup, four digit steps by 4095 and store, and per
// ratio axis setup, 48 divider steps and store; a zero half-chord ratio goes from setup straight to store.
// Synchronous reset clears the run, the job queue and the result, and restores the registers.
// ----------------------------------------------------------------------------
module magnetometer_hard_soft_iron_calibration_core #(
  parameter int COUNT_WIDTH = mag_cal_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               data_ready,
  input  logic               overflow,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic signed [15:0] mag_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [27:0] bias_x_mg,
  output logic signed [27:0] bias_y_mg,
  output logic signed [27:0] bias_z_mg,
  output logic [23:0]        ratio_x,
  output logic [23:0]        ratio_y,
  output logic [23:0]        ratio_z,
  output logic               zero_chord,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import mag_cal_pkg::*;

  // Configuration registers; unknown indexes are ignored.
  logic [11:0] run_length;
  cfg_t        cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length            <= 12'd240;
      cfg.resolution_16bit  <= 1'b1;
      cfg.sens_adjust_x     <= 8'd128;
      cfg.sens_adjust_y     <= 8'd128;
      cfg.sens_adjust_z     <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RUN_LENGTH:   run_length           <= cfg_data;
        REG_RESOLUTION:   cfg.resolution_16bit <= cfg_data[0];
        REG_SENS_X:       cfg.sens_adjust_x    <= cfg_data[7:0];
        REG_SENS_Y:       cfg.sens_adjust_y    <= cfg_data[7:0];
        REG_SENS_Z:       cfg.sens_adjust_z    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The front end takes a transaction only when the job queue has room, so a
  // closing sample never has to be held back. Two closed runs can wait in the
  // queue while the back end works on a third or holds its finished result, so
  // runs shorter than the back end's time fill the queue and stall push.
  logic accept;
  logic job_push;
  job_t job_in;
  logic job_valid;
  logic job_pop;
  job_t job_out;

  assign accept = push && !full;

  mag_cal_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk(clk), .rst(rst), .accept(accept),
    .data_ready(data_ready), .overflow(overflow),
    .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
    .run_length(run_length),
    .job_push(job_push), .job(job_in)
  );

  mag_cal_jobq u_jobq (
    .clk(clk), .rst(rst), .push(job_push), .wdata(job_in), .full(full),
    .pop(job_pop), .valid(job_valid), .rdata(job_out)
  );

  // The back end keeps its result in an output register until popped.
  mag_cal_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job_out), .job_pop(job_pop),
    .cfg(cfg), .pop(pop), .empty(empty),
    .bias_x_mg(bias_x_mg), .bias_y_mg(bias_y_mg), .bias_z_mg(bias_z_mg),
    .ratio_x(ratio_x), .ratio_y(ratio_y), .ratio_z(ratio_z),
    .zero_chord(zero_chord)
  );

endmodule
